FILE: rtl/sm3_pkg.sv
// shared types, constants and helper functions for the sm3 hash engine
package sm3_pkg;

    localparam int unsigned WordW   = 32;
    localparam int unsigned BlkWords = 16;
    localparam int unsigned Rounds  = 64;

    localparam logic [WordW-1:0] T_LOW    = 32'h79cc4519;
    localparam logic [WordW-1:0] T_HIGH   = 32'h7a879d8a;
    localparam logic [7:0]       PAD_MARK = 8'h80;

    // first byte position of the length field of a final block, and last byte position of a block
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;

    typedef logic [7:0][WordW-1:0]          cv_t;
    typedef logic [BlkWords-1:0][WordW-1:0] blk_t;

    localparam cv_t IV_WORDS = {
        32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
        32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BYTE,
        ST_MARK,
        ST_ZERO,
        ST_LEN,
        ST_CSTART,
        ST_CWAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic init;
    } core_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] x,
                                              input int unsigned n);
        return (x << n) | (x >> (WordW - n));
    endfunction

    function automatic logic [WordW-1:0] perm0(input logic [WordW-1:0] x);
        return x ^ rotl(x, 9) ^ rotl(x, 17);
    endfunction

    function automatic logic [WordW-1:0] perm1(input logic [WordW-1:0] x);
        return x ^ rotl(x, 15) ^ rotl(x, 23);
    endfunction

endpackage

FILE: rtl/sm3_hash_engine_unit.sv
// top level of the sm3 hash engine: byte packer, padding sequencer and digest output
//
// usage
//   s_ channel carries message words: data_word with byte_count valid bytes taken
//   from the top, s_tlast marks the final word of a message (end_message)
//   m_ channel returns the 256-bit digest as eight 32-bit words, index 0 first,
//   m_tlast on the eighth
// timing
//   one word in flight at a time, s_tready is high only when the engine is idle
//   a word's bytes are written one per cycle; a filled 64-byte block is then compressed
//   in the shared round unit (one sm3 round per cycle, 64 rounds)
//   finishing a message walks the padding one byte per cycle, pausing for a
//   compression whenever a block fills (one or two compressions in all), then the digest
//   words leave at one per cycle while m_tready is high
// reset and stall
//   aresetn (synchronous, active low) loads the initial value and clears the
//   length; a stalled receiver simply holds the current digest word, and no new
//   word is taken until all eight are delivered
module sm3_hash_engine_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_word [31:0], byte_count [34:32], zero fill
    input  logic        s_tlast,   // end_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // digest_word [31:0], word_index [34:32], zero fill
    output logic        m_tlast    // last_word
);

    sm3_pkg::state_t     state_reg, state_next;
    sm3_pkg::state_t     ret_reg, ret_next;
    logic [31:0]         word_reg, word_next;
    logic [2:0]          cnt_reg, cnt_next;
    logic                end_reg, end_next;
    logic [63:0]         total_reg, total_next;
    logic [5:0]          ptr_reg, ptr_next;
    logic [2:0]          idx_reg, idx_next;
    sm3_pkg::blk_t       buf_reg;

    // byte write port into the block buffer
    logic                wr_en;
    logic [5:0]          wr_pos;
    logic [7:0]          wr_byte;

    sm3_pkg::core_ctrl_t core_ctrl;
    sm3_pkg::core_stat_t core_stat;
    sm3_pkg::cv_t        cv;

    logic [2:0]          in_count;
    logic [63:0]         bit_len;
    logic                out_hs;

    // counts above four read as four
    assign in_count = (s_tdata[34:32] > 3'd4) ? 3'd4 : s_tdata[34:32];
    assign bit_len  = {total_reg[60:0], 3'b000};
    assign out_hs   = m_tvalid && m_tready;

    sm3_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (core_ctrl),
        .block   (buf_reg),
        .stat    (core_stat),
        .cv      (cv)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sm3_pkg::ST_IDLE;
            ret_reg   <= sm3_pkg::ST_BYTE;
            cnt_reg   <= '0;
            end_reg   <= 1'b0;
            total_reg <= '0;
            ptr_reg   <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            cnt_reg   <= cnt_next;
            end_reg   <= end_next;
            total_reg <= total_next;
            ptr_reg   <= ptr_next;
            idx_reg   <= idx_next;
        end
    end

    // payload: pending word and block buffer
    always_ff @(posedge aclk) begin
        word_reg <= word_next;
        if (wr_en) begin
            buf_reg[wr_pos[5:2]][{~wr_pos[1:0], 3'b000} +: 8] <= wr_byte;
        end
    end

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        word_next  = word_reg;
        cnt_next   = cnt_reg;
        end_next   = end_reg;
        total_next = total_reg;
        ptr_next   = ptr_reg;
        idx_next   = idx_reg;
        wr_en      = 1'b0;
        wr_pos     = ptr_reg;
        wr_byte    = '0;
        core_ctrl  = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;

        case (state_reg)
            sm3_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    word_next  = s_tdata[31:0];
                    cnt_next   = in_count;
                    end_next   = s_tlast;
                    state_next = sm3_pkg::ST_BYTE;
                end
            end
            // append message bytes one a cycle, pausing to compress each filled block
            sm3_pkg::ST_BYTE: begin
                if (cnt_reg == 3'd0) begin
                    state_next = end_reg ? sm3_pkg::ST_MARK : sm3_pkg::ST_IDLE;
                end else begin
                    wr_en      = 1'b1;
                    wr_pos     = total_reg[5:0];
                    wr_byte    = word_reg[31:24];
                    word_next  = {word_reg[23:0], 8'h00};
                    cnt_next   = cnt_reg - 3'd1;
                    total_next = total_reg + 64'd1;
                    if (total_reg[5:0] == sm3_pkg::LAST_POS) begin
                        ret_next   = sm3_pkg::ST_BYTE;
                        state_next = sm3_pkg::ST_CSTART;
                    end
                end
            end
            sm3_pkg::ST_MARK: begin
                wr_en    = 1'b1;
                wr_pos   = total_reg[5:0];
                wr_byte  = sm3_pkg::PAD_MARK;
                ptr_next = total_reg[5:0] + 6'd1;
                if (total_reg[5:0] == sm3_pkg::LAST_POS) begin
                    ret_next   = sm3_pkg::ST_ZERO;
                    state_next = sm3_pkg::ST_CSTART;
                end else begin
                    state_next = sm3_pkg::ST_ZERO;
                end
            end
            // zero fill up to the length field, across a block end if needed
            sm3_pkg::ST_ZERO: begin
                if (ptr_reg == sm3_pkg::LEN_POS) begin
                    state_next = sm3_pkg::ST_LEN;
                end else begin
                    wr_en    = 1'b1;
                    ptr_next = ptr_reg + 6'd1;
                    if (ptr_reg == sm3_pkg::LAST_POS) begin
                        ret_next   = sm3_pkg::ST_ZERO;
                        state_next = sm3_pkg::ST_CSTART;
                    end
                end
            end
            // bit length, most significant byte first
            sm3_pkg::ST_LEN: begin
                wr_en    = 1'b1;
                wr_byte  = 8'(bit_len >> {~ptr_reg[2:0], 3'b000});
                ptr_next = ptr_reg + 6'd1;
                if (ptr_reg == sm3_pkg::LAST_POS) begin
                    ret_next   = sm3_pkg::ST_OUT;
                    state_next = sm3_pkg::ST_CSTART;
                end
            end
            sm3_pkg::ST_CSTART: begin
                core_ctrl.start = 1'b1;
                state_next      = sm3_pkg::ST_CWAIT;
            end
            sm3_pkg::ST_CWAIT: begin
                if (core_stat.done) begin
                    state_next = ret_reg;
                    idx_next   = '0;
                end
            end
            sm3_pkg::ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7) begin
                        core_ctrl.init = 1'b1;
                        total_next     = '0;
                        state_next     = sm3_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = sm3_pkg::ST_IDLE;
            end
        endcase
    end

    // digest words come straight from the chaining registers
    assign m_tdata = {5'b00000, idx_reg, cv[idx_reg]};
    assign m_tlast = (idx_reg == 3'd7);

    // no input is taken while a digest is on offer
    a_ready_vs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("input ready while digest pending");

    // the round unit is only started when free
    a_start_free: assert property (@(posedge aclk) disable iff (!aresetn)
        core_ctrl.start |-> !core_stat.busy)
        else $error("round unit restarted while busy");

    // after the final digest word the length is cleared and output stops
    a_last_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_hs && m_tlast) |=> (!m_tvalid && total_reg == 64'd0))
        else $error("output not closed after last digest word");

    // one word at a time
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word taken while busy");

    // digest only leaves once the round unit is idle
    a_out_idle_core: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !core_stat.busy)
        else $error("digest offered during compression");

endmodule

FILE: rtl/sm3_core.sv
// iterative sm3 compression: one round a cycle with a rolling schedule window
module sm3_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  sm3_pkg::core_ctrl_t ctrl,
    input  sm3_pkg::blk_t      block,
    output sm3_pkg::core_stat_t stat,
    output sm3_pkg::cv_t       cv
);

    sm3_pkg::cv_t  cv_reg;
    sm3_pkg::blk_t win_reg;
    logic [31:0]   a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;
    logic [31:0]   tj_reg;
    logic [5:0]    round_reg;
    logic          busy_reg;

    logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, w_new;
    logic [31:0] a_next, e_next, tj_next;
    logic        early;

    always_comb begin
        early  = (round_reg < 6'd16);
        a12    = sm3_pkg::rotl(a_reg, 12);
        ss1    = sm3_pkg::rotl(a12 + e_reg + tj_reg, 7);
        ss2    = ss1 ^ a12;
        if (early) begin
            ff = a_reg ^ b_reg ^ c_reg;
            gg = e_reg ^ f_reg ^ g_reg;
        end else begin
            ff = (a_reg & b_reg) | (a_reg & c_reg) | (b_reg & c_reg);
            gg = (e_reg & f_reg) | (~e_reg & g_reg);
        end
        tt1    = ff + d_reg + ss2 + (win_reg[0] ^ win_reg[4]);
        tt2    = gg + h_reg + ss1 + win_reg[0];
        a_next = tt1;
        e_next = sm3_pkg::perm0(tt2);
        // constant rotates by one per round, switching after round 15 to the upper constant rotated by 16
        tj_next = (round_reg == 6'd15) ? sm3_pkg::rotl(sm3_pkg::T_HIGH, 16)
                                       : sm3_pkg::rotl(tj_reg, 1);
        w_new  = sm3_pkg::perm1(win_reg[0] ^ win_reg[7] ^ sm3_pkg::rotl(win_reg[13], 15))
                 ^ sm3_pkg::rotl(win_reg[3], 7) ^ win_reg[10];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            round_reg <= '0;
            cv_reg    <= sm3_pkg::IV_WORDS;
        end else if (ctrl.init) begin
            cv_reg <= sm3_pkg::IV_WORDS;
        end else if (ctrl.start) begin
            busy_reg  <= 1'b1;
            round_reg <= '0;
        end else if (busy_reg) begin
            round_reg <= round_reg + 6'd1;
            if (round_reg == 6'(sm3_pkg::Rounds - 1)) begin
                busy_reg  <= 1'b0;
                cv_reg[0] <= cv_reg[0] ^ a_next;
                cv_reg[1] <= cv_reg[1] ^ a_reg;
                cv_reg[2] <= cv_reg[2] ^ sm3_pkg::rotl(b_reg, 9);
                cv_reg[3] <= cv_reg[3] ^ c_reg;
                cv_reg[4] <= cv_reg[4] ^ e_next;
                cv_reg[5] <= cv_reg[5] ^ e_reg;
                cv_reg[6] <= cv_reg[6] ^ sm3_pkg::rotl(f_reg, 19);
                cv_reg[7] <= cv_reg[7] ^ g_reg;
            end
        end
    end

    // working variables and schedule window
    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            win_reg <= block;
            tj_reg  <= sm3_pkg::T_LOW;
            a_reg <= cv_reg[0]; b_reg <= cv_reg[1];
            c_reg <= cv_reg[2]; d_reg <= cv_reg[3];
            e_reg <= cv_reg[4]; f_reg <= cv_reg[5];
            g_reg <= cv_reg[6]; h_reg <= cv_reg[7];
        end else if (busy_reg) begin
            win_reg <= {w_new, win_reg[15:1]};
            tj_reg  <= tj_next;
            d_reg   <= c_reg;
            c_reg   <= sm3_pkg::rotl(b_reg, 9);
            b_reg   <= a_reg;
            a_reg   <= a_next;
            h_reg   <= g_reg;
            g_reg   <= sm3_pkg::rotl(f_reg, 19);
            f_reg   <= e_reg;
            e_reg   <= e_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (round_reg == 6'(sm3_pkg::Rounds - 1));
    assign cv        = cv_reg;

endmodule
